// ===== rtl/htfl_pkg.sv =====
`timescale 1ns / 1ps

package htfl_pkg;

    localparam int CAPACITY = 64;
    // Handle width, and one more bit so the fresh counter can hold CAPACITY.
    localparam int HANDLE_W = $clog2(CAPACITY);
    localparam int FRESH_W  = HANDLE_W + 1;
    localparam int DESC_W   = 64;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_UPDATE = 2'd2,
        OP_FREE   = 2'd3
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // latch the request and start the memory reads
        logic exec;    // resolve the request, write the tables, fill the result register
    } t_htfl_cmd;

endpackage

// ===== rtl/htfl_if.sv =====
`timescale 1ns / 1ps

interface htfl_req_if import htfl_pkg::*; ();
    logic                valid;
    logic                ready;
    t_op                 op;
    logic [HANDLE_W-1:0] handle;
    logic [DESC_W-1:0]   descriptor;

    modport source (output valid, output op, output handle, output descriptor, input ready);
    modport sink   (input valid, input op, input handle, input descriptor, output ready);
endinterface

interface htfl_rsp_if import htfl_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [HANDLE_W-1:0] out_handle;
    logic [DESC_W-1:0]   out_descriptor;
    logic                ok;

    modport source (output valid, output out_handle, output out_descriptor, output ok,
                    input ready);
    modport sink   (input valid, input out_handle, input out_descriptor, input ok,
                    output ready);
endinterface

// ===== rtl/htfl_ctrl.sv =====
`timescale 1ns / 1ps

module htfl_ctrl import htfl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    output logic      o_req_ready,
    input  logic      i_rsp_ready,
    output logic      o_rsp_valid,
    output t_htfl_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    logic   rsp_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        // The result register is free when empty or drained in this cycle.
        rsp_free    = !r_rsp_valid || i_rsp_ready;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (rsp_free) begin
                    o_cmd.exec  = 1'b1;
                    n_rsp_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

// ===== rtl/htfl_dp.sv =====
`timescale 1ns / 1ps

module htfl_dp import htfl_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_htfl_cmd           i_cmd,
    input  t_op                 i_op,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [DESC_W-1:0]   i_descriptor,
    output logic [HANDLE_W-1:0] o_out_handle,
    output logic [DESC_W-1:0]   o_out_descriptor,
    output logic                o_ok
);

    logic [DESC_W-1:0]   slot_mem [CAPACITY];
    logic [HANDLE_W-1:0] link_mem [CAPACITY];
    logic [CAPACITY-1:0] r_slot_vld;

    t_op                 r_op;
    logic [HANDLE_W-1:0] r_handle;
    logic [DESC_W-1:0]   r_desc;
    logic [DESC_W-1:0]   r_slot_rd;
    logic [HANDLE_W-1:0] r_link_rd;

    logic [FRESH_W-1:0]  r_next_fresh, n_next_fresh;
    logic [HANDLE_W-1:0] r_free_top, n_free_top;

    logic [HANDLE_W-1:0] r_out_handle, n_out_handle;
    logic [DESC_W-1:0]   r_out_desc, n_out_desc;
    logic                r_out_ok, n_out_ok;

    logic                h_ok;
    logic                from_free;
    logic                fresh_ok;
    logic [HANDLE_W-1:0] got;
    logic                slot_we;
    logic [HANDLE_W-1:0] slot_waddr;
    logic                vld_set;
    logic                vld_clr;
    logic                link_we;

    always_comb begin
        h_ok      = (r_handle != '0) && ({1'b0, r_handle} < FRESH_W'(CAPACITY));
        from_free = (r_free_top != '0);
        fresh_ok  = (r_next_fresh < FRESH_W'(CAPACITY));
        got       = from_free ? r_free_top : r_next_fresh[HANDLE_W-1:0];

        n_next_fresh = r_next_fresh;
        n_free_top   = r_free_top;
        n_out_handle = '0;
        n_out_desc   = '0;
        n_out_ok     = 1'b0;
        slot_we      = 1'b0;
        slot_waddr   = r_handle;
        vld_set      = 1'b0;
        vld_clr      = 1'b0;
        link_we      = 1'b0;

        case (r_op)
            OP_ALLOC: begin
                slot_waddr = got;
                if (from_free) begin
                    n_free_top = r_link_rd;
                end else if (fresh_ok) begin
                    n_next_fresh = r_next_fresh + FRESH_W'(1);
                end
                if (from_free || fresh_ok) begin
                    slot_we      = 1'b1;
                    vld_set      = 1'b1;
                    n_out_handle = got;
                    n_out_ok     = 1'b1;
                end
            end
            OP_LOOKUP: begin
                if (h_ok) begin
                    // A slot never written since reset or freed reads as zero.
                    n_out_desc = r_slot_vld[r_handle] ? r_slot_rd : '0;
                    n_out_ok   = 1'b1;
                end
            end
            OP_UPDATE: begin
                if (h_ok) begin
                    slot_we  = 1'b1;
                    vld_set  = 1'b1;
                    n_out_ok = 1'b1;
                end
            end
            OP_FREE: begin
                if (h_ok) begin
                    link_we    = 1'b1;
                    vld_clr    = 1'b1;
                    n_free_top = r_handle;
                    n_out_ok   = 1'b1;
                end
            end
            default: begin
                n_out_ok = 1'b0;
            end
        endcase
    end

    // Request latch and registered memory reads, taken on the input transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_op;
            r_handle  <= i_handle;
            r_desc    <= i_descriptor;
            r_slot_rd <= slot_mem[i_handle];
            r_link_rd <= link_mem[r_free_top];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && slot_we) begin
            slot_mem[slot_waddr] <= r_desc;
        end
        if (i_cmd.exec && link_we) begin
            link_mem[r_handle] <= r_free_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld   <= '0;
            r_next_fresh <= FRESH_W'(1);
            r_free_top   <= '0;
        end else if (i_cmd.exec) begin
            r_next_fresh <= n_next_fresh;
            r_free_top   <= n_free_top;
            if (vld_set) begin
                r_slot_vld[slot_waddr] <= 1'b1;
            end else if (vld_clr) begin
                r_slot_vld[r_handle] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_handle <= n_out_handle;
            r_out_desc   <= n_out_desc;
            r_out_ok     <= n_out_ok;
        end
    end

    assign o_out_handle     = r_out_handle;
    assign o_out_descriptor = r_out_desc;
    assign o_ok             = r_out_ok;

endmodule

// ===== rtl/handle_table_free_list.sv =====
`timescale 1ns / 1ps
// The request is latched on its transfer and resolved in ST_EXEC, which fills the
// result register; ST_EXEC waits while an earlier result still waits to be taken.
// No new request is taken until the current one is resolved, since the slot and
// link memories are read into registers first and updated afterwards.
// Reset: synchronous, active low; clears the slot valid bits and the free-list
// head and sets the fresh-handle counter to one at once, with no clearing pass.

module handle_table_free_list import htfl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    htfl_req_if.sink   i_req,
    htfl_rsp_if.source o_rsp
);

    t_htfl_cmd cmd;

    htfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    htfl_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_op             (i_req.op),
        .i_handle         (i_req.handle),
        .i_descriptor     (i_req.descriptor),
        .o_out_handle     (o_rsp.out_handle),
        .o_out_descriptor (o_rsp.out_descriptor),
        .o_ok             (o_rsp.ok)
    );

endmodule
